// ===== design/bitmap_first_free_allocator_macros.svh =====
// Assertion helpers used by the allocator.
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define BFFA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define BFFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/bffa_pkg.sv =====
`timescale 1ns / 1ps

package bffa_pkg;

   // Default map size and map word width.
   localparam int BFFA_MAP_BITS = 1024;
   localparam int BFFA_WORD_W   = 32;

   // Fixed field widths.
   localparam int BFFA_KIND_W  = 3;
   localparam int BFFA_POS_W   = 11;
   localparam int BFFA_IDX_W   = 10;
   localparam int BFFA_COUNT_W = 11;

   localparam logic [BFFA_COUNT_W-1:0] BFFA_COUNT_RESET = 11'd1024;

   // Operation codes; the unused codes act as a query.
   localparam logic [BFFA_KIND_W-1:0] KIND_SET       = 3'd0;
   localparam logic [BFFA_KIND_W-1:0] KIND_CLEAR     = 3'd1;
   localparam logic [BFFA_KIND_W-1:0] KIND_CLEAR_ALL = 3'd2;
   localparam logic [BFFA_KIND_W-1:0] KIND_LIMIT     = 3'd3;
   localparam logic [BFFA_KIND_W-1:0] KIND_QUERY     = 3'd4;

   typedef struct packed {
      logic [BFFA_KIND_W-1:0] kind;
      logic [BFFA_POS_W-1:0]  position;
   } req_type;

   typedef struct packed {
      logic                  free_found;
      logic [BFFA_IDX_W-1:0] free_index;
   } rsp_type;

endpackage

// ===== design/bffa_ram.sv =====
`timescale 1ns / 1ps

module bffa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one word, read one word with registered data.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/bitmap_first_free_allocator.sv =====
`timescale 1ns / 1ps
// Set and clear rewrite one map word when the position is usable; clear all and limit
// rewrite all NUM_WORDS words (NUM_WORDS = MAP_BITS / 32, rounded up); then each
// operation scans for the lowest clear usable flag. Throughput: one item at a time;
// the scan reads one 32-bit map word per cycle from a one-read, one-write port RAM.
// Reset: synchronous; a clearing pass zeroes every map word while no item
// is taken; bit_count returns to 1024 and the result register empties.
`include "bitmap_first_free_allocator_macros.svh"

module bitmap_first_free_allocator
   import bffa_pkg::*;
#(
   parameter int MAP_BITS = BFFA_MAP_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_item,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [BFFA_COUNT_W-1:0] csr_data
);

   localparam int WORD_W    = BFFA_WORD_W;
   localparam int BIT_W     = $clog2(WORD_W);
   localparam int NUM_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
   localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int CNT_W     = $clog2(MAP_BITS + 1);
   localparam int CMP_W     = (CNT_W > BFFA_POS_W) ? CNT_W : BFFA_POS_W;
   localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_RMW,
      ST_SWEEP,
      ST_SCAN,
      ST_HOLD
   } state_type;

   // Bits of a word whose flag index (base + bit) is at or above n.
   function automatic logic [WORD_W-1:0] ge_mask(input logic [CMP_W-1:0] base,
                                                 input logic [CMP_W-1:0] n);
      logic [CMP_W-1:0]  diff;
      logic [WORD_W-1:0] mask;
      diff = n - base;
      if (n <= base) begin
         mask = '1;
      end else if (diff >= CMP_W'(WORD_W)) begin
         mask = '0;
      end else begin
         mask = {WORD_W{1'b1}} << diff[BIT_W-1:0];
      end
      return mask;
   endfunction

   // Lowest clear bit of a word.
   function automatic logic [BIT_W:0] first_zero(input logic [WORD_W-1:0] word);
      logic             hit;
      logic [BIT_W-1:0] pos;
      hit = 1'b0;
      pos = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (!word[b]) begin
            hit = 1'b1;
            pos = BIT_W'(b);
         end
      end
      return {hit, pos};
   endfunction

   state_type               state_ff, state_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic [AW-1:0]           chk_ff, chk_in;
   logic                    pend_ff, pend_in;
   logic [BFFA_KIND_W-1:0]  op_ff, op_in;
   logic [BFFA_POS_W-1:0]   pos_ff, pos_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_item_ff, rsp_item_in;
   rsp_type                 res_ff, res_in;
   logic [BFFA_COUNT_W-1:0] bit_count_ff, bit_count_in;

   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [WORD_W-1:0]       ram_wdata;
   logic [AW-1:0]           ram_raddr;
   logic [WORD_W-1:0]       ram_rdata;

   logic [CMP_W-1:0]        lim;
   logic [CMP_W-1:0]        req_pos_ext;
   logic [CMP_W-1:0]        pos_ext;
   logic [CMP_W-1:0]        base_addr;
   logic [CMP_W-1:0]        base_chk;
   logic [CMP_W-1:0]        idx_full;
   logic [WORD_W-1:0]       scan_word;
   logic [BIT_W:0]          zero_hit;
   logic                    issue_ok;
   logic                    chk_last;
   logic                    out_free;
   logic                    fin;
   rsp_type                 fin_res;

   logic                    req_take;
   logic                    rsp_none;
   logic                    idx_zero;
   logic                    write_state;
   logic                    in_hold;

   bffa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_WORDS)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Saturate the usable count to the map size.
   assign lim = (CMP_W'(bit_count_ff) > CMP_W'(MAP_BITS)) ? CMP_W'(MAP_BITS)
                                                          : CMP_W'(bit_count_ff);

   assign req_pos_ext = CMP_W'(req_item.position);
   assign pos_ext     = CMP_W'(pos_ff);
   assign base_addr   = CMP_W'(addr_ff) << BIT_W;
   assign base_chk    = CMP_W'(chk_ff) << BIT_W;

   // Scan word unit: mask unusable flags, find the lowest clear one.
   assign scan_word = ram_rdata | ge_mask(base_chk, lim);
   assign zero_hit  = first_zero(scan_word);
   assign idx_full  = base_chk | CMP_W'(zero_hit[BIT_W-1:0]);
   assign issue_ok  = base_addr < lim;
   assign chk_last  = (lim - base_chk) <= CMP_W'(WORD_W);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      chk_in       = chk_ff;
      pend_in      = pend_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      res_in       = res_ff;
      bit_count_in = bit_count_ff;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = '0;
      ram_raddr    = addr_ff;
      fin          = 1'b0;
      fin_res      = '0;

      // Drop the result once taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Take a register write.
      if (csr_valid) begin
         bit_count_in = csr_data;
      end

      case (state_ff)
         ST_INIT: begin
            ram_we = 1'b1;
            if (addr_ff == LAST_WORD) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_item.kind;
               pos_in  = req_item.position;
               addr_in = '0;
               pend_in = 1'b0;
               case (req_item.kind)
                  KIND_SET, KIND_CLEAR: begin
                     if (req_pos_ext < lim) begin
                        ram_raddr = req_pos_ext[BIT_W +: AW];
                        addr_in   = req_pos_ext[BIT_W +: AW];
                        state_in  = ST_RMW;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  KIND_CLEAR_ALL, KIND_LIMIT: begin
                     state_in = ST_SWEEP;
                  end
                  default: begin
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end
         ST_RMW: begin
            // Modify the one flag in the word just read.
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            ram_wdata[pos_ff[BIT_W-1:0]] = (op_ff == KIND_SET);
            addr_in   = '0;
            pend_in   = 1'b0;
            state_in  = ST_SCAN;
         end
         ST_SWEEP: begin
            ram_we    = 1'b1;
            ram_wdata = (op_ff == KIND_LIMIT) ? ge_mask(base_addr, pos_ext) : '0;
            if (addr_ff == LAST_WORD) begin
               addr_in  = '0;
               pend_in  = 1'b0;
               state_in = ST_SCAN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            if (pend_ff) begin
               if (zero_hit[BIT_W]) begin
                  fin                = 1'b1;
                  fin_res.free_found = 1'b1;
                  fin_res.free_index = idx_full[BFFA_IDX_W-1:0];
               end else if (chk_last) begin
                  fin = 1'b1;
               end
            end else if (!issue_ok) begin
               fin = 1'b1;
            end
            if (fin) begin
               pend_in = 1'b0;
            end else if (issue_ok) begin
               pend_in = 1'b1;
               chk_in  = addr_ff;
               addr_in = addr_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Hand the result to the output register, or hold it while that is full.
      if (fin) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_item_in  = fin_res;
            state_in     = ST_IDLE;
         end else begin
            res_in   = fin_res;
            state_in = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bit_count_ff <= BFFA_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         bit_count_ff <= bit_count_in;
      end
      chk_ff      <= chk_in;
      op_ff       <= op_in;
      pos_ff      <= pos_in;
      rsp_item_ff <= rsp_item_in;
      res_ff      <= res_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Conditions watched by the checks below.
   assign req_take    = req_valid && !req_stall;
   assign rsp_none    = rsp_valid && !rsp_item.free_found;
   assign idx_zero    = (rsp_item.free_index == '0);
   assign write_state = (state_ff == ST_INIT) || (state_ff == ST_RMW) || (state_ff == ST_SWEEP);
   assign in_hold     = (state_ff == ST_HOLD);

   `BFFA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_take, req_stall, "no stall after accept")
   `BFFA_ASSERT_SAME(a_none_index_zero, clock, reset, rsp_none, idx_zero, "nonzero index")
   `BFFA_ASSERT_SAME(a_write_states, clock, reset, ram_we, write_state, "stray map write")
   `BFFA_ASSERT_SAME(a_hold_output_full, clock, reset, in_hold, rsp_valid, "hold with no output")

endmodule

// ===== bench/tb_bitmap_first_free_allocator.sv =====
`timescale 1ns / 1ps

module tb_bitmap_first_free_allocator;
   import bffa_pkg::*;

   localparam int MAP_BITS       = BFFA_MAP_BITS;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 100;
   localparam int TIMEOUT_CYCLES = 500000;

   // Codes with no operation of their own; the block treats them as a query.
   localparam logic [BFFA_KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
   localparam logic [BFFA_KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_item  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_item;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [BFFA_COUNT_W-1:0] csr_data  = '0;

   // Predicted allocator state and pending answers.
   logic [MAP_BITS-1:0]     occupancy_model = '0;
   logic [BFFA_COUNT_W-1:0] bit_count_model = BFFA_COUNT_RESET;
   int                      frontier        = 0;
   rsp_type                 expected_free_q[$];
   int                      mismatch_count  = 0;

   // Idle control shared by sender and receiver.
   logic idle_bursts_on = 1'b1;
   logic hold_request   = 1'b0;
   int   hold_left      = 0;
   int   burst_left     = 0;
   int   cycle_count    = 0;

   bitmap_first_free_allocator #(
      .MAP_BITS(MAP_BITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int usable_flags();
      return (int'(bit_count_model) > MAP_BITS) ? MAP_BITS : int'(bit_count_model);
   endfunction

   // Apply one operation to the predicted map and find the lowest clear usable flag.
   function automatic rsp_type apply_and_find_free(input req_type item);
      rsp_type answer;
      int      usable;
      usable = usable_flags();
      answer = '0;
      case (item.kind)
         KIND_SET: begin
            if (int'(item.position) < usable) occupancy_model[item.position] = 1'b1;
         end
         KIND_CLEAR: begin
            if (int'(item.position) < usable) occupancy_model[item.position] = 1'b0;
         end
         KIND_CLEAR_ALL: begin
            occupancy_model = '0;
         end
         KIND_LIMIT: begin
            for (int i = 0; i < MAP_BITS; i++)
               occupancy_model[i] = (i < int'(item.position)) ? 1'b0 : 1'b1;
         end
         default: begin
         end
      endcase
      for (int i = 0; i < usable; i++) begin
         if (!occupancy_model[i]) begin
            answer.free_found = 1'b1;
            answer.free_index = i[BFFA_IDX_W-1:0];
            break;
         end
      end
      frontier = answer.free_found ? int'(answer.free_index) : usable;
      return answer;
   endfunction

   // Offer one item, hold it until taken, then record its answer.
   task automatic send_request(input logic [BFFA_KIND_W-1:0] kind,
                               input logic [BFFA_POS_W-1:0] position);
      req_type item;
      item.kind     = kind;
      item.position = position;
      if (idle_bursts_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      do @(posedge clock); while (req_stall);
      expected_free_q.push_back(apply_and_find_free(item));
   endtask

   // Drop valid and wait until every answer has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_free_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_bit_count(input logic [BFFA_COUNT_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid       <= 1'b0;
      bit_count_model  = value;
   endtask

   // Pick an operation and a position, mostly around the current free frontier.
   task automatic send_random_request();
      int                      usable;
      int                      pick;
      logic [BFFA_KIND_W-1:0]  kind;
      logic [BFFA_POS_W-1:0]   position;
      usable = usable_flags();
      pick   = $urandom_range(0, 99);
      if (pick < 45)      kind = KIND_SET;
      else if (pick < 65) kind = KIND_CLEAR;
      else if (pick < 75) kind = KIND_QUERY;
      else if (pick < 80) kind = KIND_CLEAR_ALL;
      else if (pick < 88) kind = KIND_LIMIT;
      else                kind = BFFA_KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
      pick = $urandom_range(0, 9);
      if (pick < 5)      position = BFFA_POS_W'(frontier + $urandom_range(0, 3));
      else if (pick < 8) position = BFFA_POS_W'($urandom_range(0, usable));
      else if (pick < 9) position = BFFA_POS_W'(usable - 2 + $urandom_range(0, 3));
      else               position = BFFA_POS_W'($urandom);
      send_request(kind, position);
   endtask

   task automatic test_reset_state();
      send_request(KIND_QUERY, 11'd0);
   endtask

   task automatic test_set_clear();
      send_request(KIND_SET, 11'd0);
      send_request(KIND_SET, 11'd1);
      send_request(KIND_CLEAR, 11'd0);
      send_request(KIND_SET, 11'd1023);
      // Out-of-range writes leave the map alone.
      send_request(KIND_SET, 11'd1024);
      send_request(KIND_SET, 11'd2047);
      send_request(KIND_CLEAR, 11'd2047);
      send_request(KIND_CLEAR, 11'd1);
   endtask

   task automatic test_limit_and_clear_all();
      send_request(KIND_LIMIT, 11'd0);
      send_request(KIND_CLEAR_ALL, 11'd0);
      send_request(KIND_LIMIT, 11'd1);
      send_request(KIND_LIMIT, 11'd1023);
      send_request(KIND_LIMIT, 11'd2047);
      send_request(KIND_LIMIT, 11'd0);
   endtask

   task automatic test_unused_kinds();
      for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
         send_request(BFFA_KIND_W'(k), 11'd0);
   endtask

   // Shrink and grow the usable count; stored flags reappear as last written.
   task automatic test_usable_count();
      write_bit_count(11'd1024);
      send_request(KIND_LIMIT, 11'd0);
      send_request(KIND_CLEAR, 11'd900);
      write_bit_count(11'd16);
      send_request(KIND_QUERY, 11'd0);
      send_request(KIND_CLEAR, 11'd5);
      write_bit_count(11'd0);
      send_request(KIND_QUERY, 11'd0);
      send_request(KIND_CLEAR, 11'd3);
      write_bit_count(11'd2047);
      send_request(KIND_QUERY, 11'd0);
      send_request(KIND_SET, 11'd5);
      write_bit_count(11'd1024);
   endtask

   // Stall the result side for a long stretch while items keep coming.
   task automatic test_backpressure();
      drain_results();
      idle_bursts_on = 1'b0;
      hold_request   = 1'b1;
      repeat (12) send_random_request();
      idle_bursts_on = 1'b1;
   endtask

   task automatic run_random_phase(input logic [BFFA_COUNT_W-1:0] count_setting,
                                   input int item_total);
      write_bit_count(count_setting);
      repeat (item_total) send_random_request();
   endtask

   task automatic test_random();
      run_random_phase(11'd1024, 100);
      run_random_phase(11'd1, 50);
      run_random_phase(11'd8, 100);
      run_random_phase(11'd33, 100);
      run_random_phase(11'd0, 30);
      run_random_phase(11'd100, 120);
      run_random_phase(11'd2047, 100);
      run_random_phase(11'd513, 120);
      run_random_phase(11'd32, 100);
      // Run the last part with no idling on either side.
      drain_results();
      idle_bursts_on = 1'b0;
      run_random_phase(11'd1024, 120);
   endtask

   // Drive result-side stall: the long hold first, then random bursts.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         rsp_stall   <= 1'b1;
         hold_left   <= HOLD_CYCLES - 1;
      end else if (burst_left != 0) begin
         rsp_stall  <= 1'b1;
         burst_left <= burst_left - 1;
      end else if (idle_bursts_on && $urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         burst_left <= $urandom_range(0, 7);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each taken result with the oldest pending answer.
   always @(posedge clock) begin : check_results
      rsp_type predicted;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_free_q.size() == 0) begin
            $error("unexpected result: free_found %0d free_index %0d",
                   rsp_item.free_found, rsp_item.free_index);
            mismatch_count++;
         end else begin
            predicted = expected_free_q.pop_front();
            if (rsp_item.free_found !== predicted.free_found) begin
               $error("free_found: expected %0d, actual %0d",
                      predicted.free_found, rsp_item.free_found);
               mismatch_count++;
            end
            if (rsp_item.free_index !== predicted.free_index) begin
               $error("free_index: expected %0d, actual %0d",
                      predicted.free_index, rsp_item.free_index);
               mismatch_count++;
            end
         end
      end
   end

   // End the run if it hangs.
   initial begin
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_set_clear();
      test_limit_and_clear_all();
      test_unused_kinds();
      test_usable_count();
      test_backpressure();
      test_random();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_free_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== bitmap_first_free_allocator.f =====
+incdir+design
design/bffa_pkg.sv
design/bffa_ram.sv
design/bitmap_first_free_allocator.sv
bench/tb_bitmap_first_free_allocator.sv
